// ===== rtl/core/smema_pkg.sv =====
// ----------------------------------------------------------------------------
// smema_pkg
// Shared types, codes and helpers for the SMEMA entry conveyor controller.
// ----------------------------------------------------------------------------
package smema_pkg;

  localparam int TIMER_BITS_DEF = 24;
  localparam int TMO_W          = 24;
  localparam int SPEED_W        = 2;
  localparam int CFG_ADDR_W     = 3;
  localparam int CFG_DATA_W     = 24;

  localparam logic [SPEED_W-1:0]    SPEED_MID         = 2'd1;
  localparam logic [SPEED_W-1:0]    SPEED_HIGH        = 2'd2;
  localparam logic [TMO_W-1:0]      TIMEOUT_RESET     = 24'd10000;

  localparam logic [CFG_ADDR_W-1:0] REG_INBOUND_SPEED    = 3'd0;
  localparam logic [CFG_ADDR_W-1:0] REG_OUTBOUND_SPEED   = 3'd1;
  localparam logic [CFG_ADDR_W-1:0] REG_INBOUND_TIMEOUT  = 3'd2;
  localparam logic [CFG_ADDR_W-1:0] REG_OUTBOUND_TIMEOUT = 3'd3;
  localparam logic [CFG_ADDR_W-1:0] REG_DRY_RUN          = 3'd4;

  typedef enum logic [3:0] {
    ST_STOP       = 4'd0,
    ST_START      = 4'd1,
    ST_WAIT_PREV  = 4'd2,
    ST_SEND_PREV  = 4'd3,
    ST_WAIT_POS   = 4'd4,
    ST_SEND_NEXT  = 4'd5,
    ST_WAIT_NEXT  = 4'd6,
    ST_WAIT_OUT   = 4'd7,
    ST_WAIT_BUSY  = 4'd8
  } step_t;

  typedef enum logic [1:0] {
    ALARM_NONE     = 2'd0,
    ALARM_INBOUND  = 2'd1,
    ALARM_OUTBOUND = 2'd2
  } alarm_t;

  typedef struct packed {
    logic entry_sensor;
    logic seat_sensor;
    logic upstream_ready;
    logic downstream_busy;
    logic start_request;
    logic stop_request;
  } in_word_t;

  typedef struct packed {
    logic               upstream_busy;
    logic               downstream_ready;
    logic               belt_run;
    logic [SPEED_W-1:0] belt_speed;
    logic               board_ready;
    alarm_t             alarm_code;
    step_t              step_now;
    logic               handoff_pulse;
    logic               free_timer_pulse;
  } out_word_t;

  // A speed code of three saturates to high speed.
  function automatic logic [SPEED_W-1:0] clamp_speed(input logic [SPEED_W-1:0] spd);
    clamp_speed = (spd > SPEED_HIGH) ? SPEED_HIGH : spd;
  endfunction

endpackage

// ===== rtl/core/smema_entry_conveyor_control.sv =====
// ----------------------------------------------------------------------------
// smema_entry_conveyor_control
// Each accepted input word yields a registered result word.
// Throughput: one word per cycle unless stalled; the result register frees as taken.
// Reset: synchronous, active low; the step machine returns to STOP, the timer
// clears, the belt stops at mid speed and the registers take their defaults.
// ----------------------------------------------------------------------------
module smema_entry_conveyor_control
  import smema_pkg::*;
#(
  parameter int TIMER_BITS = TIMER_BITS_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_we,
  input  logic [CFG_ADDR_W-1:0] cfg_addr,
  input  logic [CFG_DATA_W-1:0] cfg_wdata,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  in_word_t              in_data,
  output logic                  out_valid,
  input  logic                  out_stall,
  output out_word_t             out_data
);

  localparam int CMP_W = (TIMER_BITS > TMO_W) ? TIMER_BITS : TMO_W;

  logic [SPEED_W-1:0]    in_speed_r;
  logic [SPEED_W-1:0]    out_speed_r;
  logic [TMO_W-1:0]      in_tmo_r;
  logic [TMO_W-1:0]      out_tmo_r;
  logic                  dry_run_r;

  step_t                 step_r, step_nxt;
  logic [TIMER_BITS-1:0] elapsed_r, elapsed_nxt;
  logic                  up_busy_r, up_busy_nxt;
  logic                  dn_ready_r, dn_ready_nxt;
  logic                  belt_run_r, belt_run_nxt;
  logic [SPEED_W-1:0]    belt_speed_r, belt_speed_nxt;
  logic                  board_ready_r, board_ready_nxt;
  alarm_t                alarm;
  logic                  handoff;
  logic                  free_pulse;

  logic                  out_valid_r;
  out_word_t             out_data_r;

  logic                  accept;
  logic                  stop_now;
  logic [TIMER_BITS-1:0] timer_inc;
  logic [TMO_W-1:0]      limit;
  logic                  timed_out;

  assign in_stall  = out_valid_r & out_stall;
  assign accept    = in_valid & ~in_stall;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_speed_r  <= SPEED_MID;
      out_speed_r <= SPEED_MID;
      in_tmo_r    <= TIMEOUT_RESET;
      out_tmo_r   <= TIMEOUT_RESET;
      dry_run_r   <= 1'b0;
    end else if (cfg_we) begin
      case (cfg_addr)
        REG_INBOUND_SPEED:    in_speed_r  <= cfg_wdata[SPEED_W-1:0];
        REG_OUTBOUND_SPEED:   out_speed_r <= cfg_wdata[SPEED_W-1:0];
        REG_INBOUND_TIMEOUT:  in_tmo_r    <= cfg_wdata[TMO_W-1:0];
        REG_OUTBOUND_TIMEOUT: out_tmo_r   <= cfg_wdata[TMO_W-1:0];
        REG_DRY_RUN:          dry_run_r   <= cfg_wdata[0];
        default: ;
      endcase
    end
  end

  // Stops are honored everywhere except while a board is in motion.
  assign stop_now = in_data.stop_request &
                    (step_r != ST_WAIT_POS) & (step_r != ST_WAIT_OUT) &
                    (step_r != ST_WAIT_BUSY);

  assign timer_inc = (&elapsed_r) ? elapsed_r : elapsed_r + TIMER_BITS'(1);
  assign limit     = (step_r == ST_WAIT_POS) ? in_tmo_r : out_tmo_r;
  assign timed_out = CMP_W'(timer_inc) > CMP_W'(limit);

  always_comb begin
    step_nxt = step_r;
    if (stop_now) begin
      step_nxt = ST_STOP;
    end else begin
      case (step_r)
        ST_START: begin
          if (in_data.entry_sensor || in_data.seat_sensor) begin
            step_nxt = ST_WAIT_POS;
          end else if (!dry_run_r) begin
            step_nxt = ST_WAIT_PREV;
          end
        end
        ST_WAIT_PREV: step_nxt = in_data.upstream_ready ? ST_SEND_PREV : ST_START;
        ST_SEND_PREV: step_nxt = ST_WAIT_POS;
        ST_WAIT_POS: begin
          if (in_data.seat_sensor) begin
            step_nxt = ST_SEND_NEXT;
          end else if (timed_out) begin
            step_nxt = ST_STOP;
          end
        end
        ST_SEND_NEXT: step_nxt = ST_WAIT_NEXT;
        ST_WAIT_NEXT: begin
          if (!in_data.downstream_busy) begin
            step_nxt = ST_WAIT_OUT;
          end
        end
        ST_WAIT_OUT: begin
          if (!in_data.seat_sensor) begin
            step_nxt = ST_WAIT_BUSY;
          end else if (timed_out) begin
            step_nxt = ST_STOP;
          end
        end
        ST_WAIT_BUSY: begin
          if (in_data.downstream_busy) begin
            step_nxt = ST_START;
          end else if (timed_out) begin
            step_nxt = ST_STOP;
          end
        end
        default: step_nxt = in_data.start_request ? ST_START : ST_STOP;
      endcase
    end
  end

  always_comb begin
    elapsed_nxt     = elapsed_r;
    up_busy_nxt     = up_busy_r;
    dn_ready_nxt    = dn_ready_r;
    belt_run_nxt    = belt_run_r;
    belt_speed_nxt  = belt_speed_r;
    board_ready_nxt = board_ready_r;
    alarm           = ALARM_NONE;
    handoff         = 1'b0;
    free_pulse      = 1'b0;
    if (stop_now) begin
      up_busy_nxt     = 1'b0;
      dn_ready_nxt    = 1'b0;
      board_ready_nxt = 1'b0;
      belt_run_nxt    = 1'b0;
      belt_speed_nxt  = clamp_speed(out_speed_r);
    end else begin
      case (step_r)
        ST_START: begin
          if (in_data.entry_sensor) begin
            up_busy_nxt    = 1'b1;
            belt_run_nxt   = 1'b1;
            belt_speed_nxt = clamp_speed(in_speed_r);
            elapsed_nxt    = '0;
          end else if (in_data.seat_sensor) begin
            up_busy_nxt = 1'b1;
            elapsed_nxt = '0;
          end else if (dry_run_r) begin
            up_busy_nxt = 1'b1;
          end else begin
            board_ready_nxt = 1'b0;
            up_busy_nxt     = 1'b0;
            dn_ready_nxt    = 1'b0;
          end
        end
        ST_SEND_PREV: begin
          up_busy_nxt    = 1'b0;
          belt_run_nxt   = 1'b1;
          belt_speed_nxt = clamp_speed(in_speed_r);
          elapsed_nxt    = '0;
        end
        ST_WAIT_POS: begin
          if (in_data.seat_sensor) begin
            board_ready_nxt = 1'b1;
            up_busy_nxt     = 1'b1;
            dn_ready_nxt    = 1'b1;
            belt_run_nxt    = 1'b0;
            belt_speed_nxt  = clamp_speed(in_speed_r);
          end else begin
            elapsed_nxt = timer_inc;
            if (timed_out) begin
              belt_run_nxt   = 1'b0;
              belt_speed_nxt = clamp_speed(in_speed_r);
              alarm          = ALARM_INBOUND;
            end
          end
        end
        ST_SEND_NEXT: dn_ready_nxt = 1'b1;
        ST_WAIT_NEXT: begin
          if (!in_data.downstream_busy) begin
            belt_run_nxt   = 1'b1;
            belt_speed_nxt = clamp_speed(out_speed_r);
            handoff        = 1'b1;
            elapsed_nxt    = '0;
          end
        end
        ST_WAIT_OUT: begin
          if (!in_data.seat_sensor) begin
            free_pulse = 1'b1;
          end else begin
            elapsed_nxt = timer_inc;
            if (timed_out) begin
              belt_run_nxt   = 1'b0;
              belt_speed_nxt = clamp_speed(in_speed_r);
              alarm          = ALARM_OUTBOUND;
            end
          end
        end
        ST_WAIT_BUSY: begin
          if (in_data.downstream_busy) begin
            belt_run_nxt   = 1'b0;
            belt_speed_nxt = clamp_speed(out_speed_r);
          end else begin
            elapsed_nxt = timer_inc;
            if (timed_out) begin
              belt_run_nxt   = 1'b0;
              belt_speed_nxt = clamp_speed(in_speed_r);
              alarm          = ALARM_OUTBOUND;
            end
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      step_r        <= ST_STOP;
      elapsed_r     <= '0;
      up_busy_r     <= 1'b0;
      dn_ready_r    <= 1'b0;
      belt_run_r    <= 1'b0;
      belt_speed_r  <= SPEED_MID;
      board_ready_r <= 1'b0;
    end else if (accept) begin
      step_r        <= step_nxt;
      elapsed_r     <= elapsed_nxt;
      up_busy_r     <= up_busy_nxt;
      dn_ready_r    <= dn_ready_nxt;
      belt_run_r    <= belt_run_nxt;
      belt_speed_r  <= belt_speed_nxt;
      board_ready_r <= board_ready_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (accept) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      out_data_r.upstream_busy    <= up_busy_nxt;
      out_data_r.downstream_ready <= dn_ready_nxt;
      out_data_r.belt_run         <= belt_run_nxt;
      out_data_r.belt_speed       <= belt_speed_nxt;
      out_data_r.board_ready      <= board_ready_nxt;
      out_data_r.alarm_code       <= alarm;
      out_data_r.step_now         <= step_nxt;
      out_data_r.handoff_pulse    <= handoff;
      out_data_r.free_timer_pulse <= free_pulse;
    end
  end

endmodule
